>>> sv/sfcc_pkg.sv
// shared types, constants and crc helper for the sensor frame checker
package sfcc_pkg;

	localparam logic [7:0]  CRC_POLY     = 8'h31;
	localparam logic [15:0] STATUS_MASK  = 16'hfffc;

	localparam logic [30:0] TEMP_SCALE   = 31'd17572;
	// 4685 * 65536
	localparam logic signed [31:0] TEMP_OFFSET = 32'sd307036160;

	localparam logic [29:0] RH_MUL       = 30'd15625;
	localparam int          RH_SHIFT     = 13;
	localparam logic [16:0] RH_OFFSET    = 17'd6000;
	localparam logic [16:0] RH_HALF      = 17'd500;
	// offset minus half, for the rounded quotient
	localparam logic [16:0] RH_OFS_HALF  = 17'd5500;
	// ceil(2^27 / 1000), exact for dividends below 2^17
	localparam logic [17:0] RH_RECIP     = 18'd134218;
	localparam int          RH_RECIP_SH  = 27;

	typedef struct packed {
		logic        crc_ok;
		logic        kind;
		logic [15:0] raw;
		logic [30:0] temp_prod;
		logic [16:0] rh_scaled;
	} mid_t;

	// one byte through the msb-first crc-8 register, initial value 0
	function automatic logic [7:0] crc8_byte(input logic [7:0] din);
		logic [7:0] crc;
		crc = din;
		for (int i = 0; i < 8; i++) begin
			if (crc[7]) begin
				crc = {crc[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				crc = {crc[6:0], 1'b0};
			end
		end
		return crc;
	endfunction

endpackage

>>> sv/sfcc_front.sv
// input register, crc check and constant products for the frame checker
module sfcc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               in_kind,
	input  logic [23:0]        in_frame,
	output logic               out_valid,
	input  logic               out_ready,
	output sfcc_pkg::mid_t     out_mid
);

	logic               valid_s1;
	logic               kind_s1;
	logic [23:0]        frame_s1;
	logic               valid_s2;
	sfcc_pkg::mid_t     mid_s2;
	sfcc_pkg::mid_t     mid_d;
	logic               ready_s2;
	logic [7:0]         hi;
	logic [7:0]         lo;
	logic [7:0]         chk;
	logic [15:0]        raw;
	logic [29:0]        rh_prod;

	assign ready_s2 = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || ready_s2;

	always_comb begin
		hi  = frame_s1[7:0];
		lo  = frame_s1[15:8];
		chk = frame_s1[23:16];
		raw = {hi, lo} & sfcc_pkg::STATUS_MASK;
		rh_prod = {14'b0, raw} * sfcc_pkg::RH_MUL;
		mid_d.crc_ok    = (sfcc_pkg::crc8_byte(sfcc_pkg::crc8_byte(hi) ^ lo) == chk);
		mid_d.kind      = kind_s1;
		mid_d.raw       = raw;
		mid_d.temp_prod = {15'b0, raw} * sfcc_pkg::TEMP_SCALE;
		mid_d.rh_scaled = rh_prod[sfcc_pkg::RH_SHIFT +: 17];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1  <= in_kind;
			frame_s1 <= in_frame;
		end
		if (ready_s2 && valid_s1) mid_s2 <= mid_d;
	end

	assign out_valid = valid_s2;
	assign out_mid   = mid_s2;

endmodule

>>> sv/sfcc_back.sv
// unit conversion and result register for the frame checker
module sfcc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  sfcc_pkg::mid_t     in_mid,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               out_ok,
	output logic [15:0]        out_raw,
	output logic [14:0]        out_meas
);

	logic               valid_q;
	logic               ok_q;
	logic [15:0]        raw_q;
	logic [14:0]        meas_q;
	logic signed [31:0] temp_num;
	logic [14:0]        temp_res;
	logic               temp_up;
	logic [16:0]        rh_y;
	logic [34:0]        rh_prod;
	logic [14:0]        meas_d;

	assign in_ready = !valid_q || out_ready;

	always_comb begin
		temp_num = $signed({1'b0, in_mid.temp_prod}) - sfcc_pkg::TEMP_OFFSET;
		// floor shift, then step up for a negative value with a fraction
		temp_up  = temp_num[31] && (temp_num[15:0] != 16'd0);
		temp_res = temp_num[30:16] + {14'b0, temp_up};
		// negative intermediate clamps to zero, which rounds to zero
		if (in_mid.rh_scaled < sfcc_pkg::RH_OFFSET) begin
			rh_y = sfcc_pkg::RH_HALF;
		end else begin
			rh_y = in_mid.rh_scaled - sfcc_pkg::RH_OFS_HALF;
		end
		rh_prod = {18'b0, rh_y} * {17'b0, sfcc_pkg::RH_RECIP};
		if (in_mid.kind) begin
			meas_d = {7'b0, rh_prod[sfcc_pkg::RH_RECIP_SH +: 8]};
		end else begin
			meas_d = temp_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ok_q   <= in_mid.crc_ok;
			raw_q  <= in_mid.crc_ok ? in_mid.raw : 16'd0;
			meas_q <= in_mid.crc_ok ? meas_d : 15'd0;
		end
	end

	assign out_valid = valid_q;
	assign out_ok    = ok_q;
	assign out_raw   = raw_q;
	assign out_meas  = meas_q;

endmodule

>>> sv/sensor_frame_check_and_convert.sv
// sensor frame checker top: crc-8 check, status masking and unit conversion
// throughput: one frame per cycle unless m_tready holds off the result;
// an accepted request passes through the three-stage register pipeline
// (input register, product register after the constant multiplies, result register)
// reset: arst_n clears all stage valid flags; payload registers are not reset
module sensor_frame_check_and_convert (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // data_high[7:0], data_low[15:8], check_byte[23:16]
	input  logic        s_tuser,  // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // raw_reading[15:0], measurement[30:16], zero[31]
	output logic        m_tuser   // valid_res
);

	logic               mid_valid;
	logic               mid_ready;
	sfcc_pkg::mid_t     mid;
	logic [15:0]        raw;
	logic [14:0]        meas;

	sfcc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_kind   (s_tuser),
		.in_frame  (s_tdata),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.out_mid   (mid)
	);

	sfcc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mid_valid),
		.in_ready  (mid_ready),
		.in_mid    (mid),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_ok    (m_tuser),
		.out_raw   (raw),
		.out_meas  (meas)
	);

	assign m_tdata = {1'b0, meas, raw};

	// failed check carries an all-zero payload
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == 32'd0)
		else $error("failed frame with nonzero payload");

	// status bits never reach the result
	a_status_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] == 2'b00)
		else $error("status bits not masked");

	// converted value stays in the documented range
	a_meas_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[30:16]) >= -15'sd4685 &&
			$signed(m_tdata[30:16]) <= 15'sd12885))
		else $error("measurement out of range");

	// an empty result register means the whole pipeline can take a request
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

endmodule

>>> bench/testbench.sv
// self-checking bench for the sensor frame checker: crc, status masking and conversion
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic KIND_TEMP = 1'b0;
	localparam logic KIND_RH   = 1'b1;

	localparam logic [23:0] CRC_DIVISOR = 24'h000131;
	localparam logic [15:0] READING_MASK = 16'hfffc;
	localparam longint T_SCALE  = 17572;
	localparam longint T_OFFSET = 4685;
	localparam longint T_DENOM  = 65536;
	localparam longint H_MUL    = 15625;
	localparam int     H_SHIFT  = 13;
	localparam longint H_OFFSET = 6000;
	localparam longint H_DIV    = 1000;

	localparam int RANDOM_FRAMES = 1950;
	localparam int IDLE_PCT      = 22;
	localparam int HOLD_AT       = 250;
	localparam int HOLD_CYCLES   = 300;
	localparam int STALL_LIMIT   = 2000;
	localparam int DRAIN_CYCLES  = 12;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_high;
		logic [7:0] data_low;
		logic [7:0] check_byte;
	} frame_t;

	typedef struct packed {
		logic        valid_res;
		logic [15:0] raw_reading;
		logic [14:0] measurement;
	} reading_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tuser;

	frame_t   pending_frames[$];
	reading_t expected_readings[$];
	int       fault_count = 0;
	int       readings_seen = 0;
	int       stall_cycles = 0;
	int       hold_left = 0;
	logic     hold_done = 1'b0;

	sensor_frame_check_and_convert uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// remainder of word followed by a zero byte, divided by x^8+x^5+x^4+1
	function automatic logic [7:0] crc8_of(input logic [15:0] word);
		logic [23:0] rem;
		rem = {word, 8'h00};
		for (int b = 23; b >= 8; b--) begin
			if (rem[b]) begin
				rem = rem ^ (CRC_DIVISOR << (b - 8));
			end
		end
		return rem[7:0];
	endfunction

	function automatic reading_t convert_frame(input logic kind, input logic [23:0] data);
		reading_t res;
		logic [15:0] word;
		longint num;
		longint x;
		word = {data[7:0], data[15:8]};
		res = '0;
		if (crc8_of(word) == data[23:16]) begin
			res.valid_res = 1'b1;
			res.raw_reading = word & READING_MASK;
			if (kind == KIND_RH) begin
				x = ((longint'(res.raw_reading) * H_MUL) >>> H_SHIFT) - H_OFFSET;
				if (x < 0) begin
					x = 0;
				end
				num = (x + H_DIV / 2) / H_DIV;
			end else begin
				// signed division truncates toward zero
				num = (longint'(res.raw_reading) * T_SCALE - T_OFFSET * T_DENOM) / T_DENOM;
			end
			res.measurement = num[14:0];
		end
		return res;
	endfunction

	task automatic add_frame(input logic kind, input logic [15:0] word, input logic [7:0] chk);
		pending_frames.push_back('{kind, word[15:8], word[7:0], chk});
	endtask

	task automatic add_good(input logic kind, input logic [15:0] word);
		add_frame(kind, word, crc8_of(word));
	endtask

	// sender: no idling while the middle of the queue goes out
	wire tx_calm = pending_frames.size() >= 500 && pending_frames.size() <= 900;
	wire rx_calm = readings_seen >= 1050 && readings_seen <= 1500;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_readings.push_back(convert_frame(s_tuser, s_tdata));
			end
			if (!s_tvalid || s_tready) begin
				if (pending_frames.size() != 0 && (tx_calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					s_tvalid <= 1'b1;
					s_tuser <= pending_frames[0].kind;
					s_tdata <= {pending_frames[0].check_byte, pending_frames[0].data_low,
						pending_frames[0].data_high};
					pending_frames.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				readings_seen <= readings_seen + 1;
				if (expected_readings.size() == 0) begin
					$error("unexpected result: tuser %0b tdata %h", m_tuser, m_tdata);
					fault_count++;
				end else begin
					if (m_tuser !== expected_readings[0].valid_res) begin
						$error("valid_res: expected %0b, got %0b",
							expected_readings[0].valid_res, m_tuser);
						fault_count++;
					end
					if (m_tdata[15:0] !== expected_readings[0].raw_reading) begin
						$error("raw_reading: expected %h, got %h",
							expected_readings[0].raw_reading, m_tdata[15:0]);
						fault_count++;
					end
					if (m_tdata[30:16] !== expected_readings[0].measurement) begin
						$error("measurement: expected %0d, got %0d",
							$signed(expected_readings[0].measurement), $signed(m_tdata[30:16]));
						fault_count++;
					end
					if (m_tdata[31] !== 1'b0) begin
						$error("pad bit: expected 0, got %0b", m_tdata[31]);
						fault_count++;
					end
					expected_readings.pop_front();
				end
			end
			// one long hold-off so the pipeline fills and stalls the request side
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else if (!hold_done && readings_seen >= HOLD_AT) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= rx_calm || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		logic [15:0] w;
		logic [7:0]  c;
		int          pick;
		int          flip;

		// extremes and status bits
		add_good(KIND_TEMP, 16'h0000);
		add_good(KIND_RH, 16'h0000);
		add_good(KIND_TEMP, 16'hffff);
		add_good(KIND_RH, 16'hffff);
		add_good(KIND_TEMP, 16'h0003);
		add_good(KIND_RH, 16'hfffc);
		add_good(KIND_TEMP, 16'h8000);
		add_good(KIND_RH, 16'h4e85);
		// temperature around zero, truncation toward zero
		add_good(KIND_TEMP, 16'h4440);
		add_good(KIND_TEMP, 16'h4444);
		add_good(KIND_TEMP, 16'h4448);
		add_good(KIND_TEMP, 16'h4000);
		// negative humidity intermediate clamps to zero
		add_good(KIND_RH, 16'h0c00);
		add_good(KIND_RH, 16'h0c44);
		add_good(KIND_RH, 16'h0c4c);
		add_good(KIND_RH, 16'h0c50);
		// crc failures
		add_frame(KIND_TEMP, 16'h4e85, crc8_of(16'h4e85) ^ 8'h01);
		add_frame(KIND_RH, 16'h683a, crc8_of(16'h683a) ^ 8'h80);
		add_frame(KIND_RH, 16'h0000, 8'hff);
		add_frame(KIND_TEMP, 16'hffff, 8'h00);
		add_frame(KIND_RH, 16'h1334, crc8_of(16'h1234));
		add_frame(KIND_TEMP, 16'h1235, crc8_of(16'h1234));

		// mostly good frames, some with random or single-bit corrupted bytes
		for (int i = 0; i < RANDOM_FRAMES; i++) begin
			w = 16'($urandom);
			c = crc8_of(w);
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				c = 8'($urandom);
			end else if (pick < 30) begin
				flip = $urandom_range(0, 23);
				if (flip < 16) begin
					w = w ^ (16'h0001 << flip);
				end else begin
					c = c ^ (8'h01 << (flip - 16));
				end
			end
			add_frame(1'($urandom_range(0, 1)), w, c);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while ((pending_frames.size() != 0 || s_tvalid || expected_readings.size() != 0)
				&& stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
		end

		if (stall_cycles >= STALL_LIMIT) begin
			$error("no request moved for %0d cycles", STALL_LIMIT);
			$display("testbench: errors");
		end else begin
			repeat (DRAIN_CYCLES) @(posedge clk);
			if (fault_count == 0 && expected_readings.size() == 0) begin
				$display("testbench: clean");
			end else begin
				if (expected_readings.size() != 0) begin
					$error("%0d results never arrived", expected_readings.size());
				end
				$display("testbench: errors");
			end
		end
		$finish;
	end

endmodule
